// ===== rtl/slfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared constants and types of the sync/length frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

  localparam int unsigned PAYLOAD_CAPACITY = 32;
  localparam int unsigned PIDX_W           = $clog2(PAYLOAD_CAPACITY);
  localparam int unsigned STORED_W         = 6;
  localparam int unsigned INDEX_W          = 5;
  localparam int unsigned POS_W            = 17;
  localparam int unsigned HDR_BYTES        = 16;
  localparam int unsigned OUT_TDATA_W      = 120;

  localparam logic [7:0] SYNC_FIRST  = 8'h81;
  localparam logic [7:0] SYNC_SECOND = 8'h88;

  // header byte offsets (big-endian fields)
  localparam logic [3:0] HDR_WIDTH_HI  = 4'd4;
  localparam logic [3:0] HDR_WIDTH_LO  = 4'd5;
  localparam logic [3:0] HDR_HEIGHT_HI = 4'd6;
  localparam logic [3:0] HDR_HEIGHT_LO = 4'd7;
  localparam logic [3:0] HDR_RATE_HI   = 4'd8;
  localparam logic [3:0] HDR_RATE_LO   = 4'd9;
  localparam logic [3:0] HDR_NUM_B3    = 4'd10;
  localparam logic [3:0] HDR_NUM_B2    = 4'd11;
  localparam logic [3:0] HDR_NUM_B1    = 4'd12;
  localparam logic [3:0] HDR_NUM_B0    = 4'd13;
  localparam logic [3:0] HDR_LEN_HI    = 4'd14;
  localparam logic [3:0] HDR_LEN_LO    = 4'd15;

  typedef struct packed {
    logic [15:0]         width;
    logic [15:0]         height;
    logic [15:0]         rate;
    logic [31:0]         number;
    logic [15:0]         declared;
    logic [STORED_W-1:0] stored;
  } slfp_frame_t;

endpackage

// ===== rtl/sync_length_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_parser
// Byte-stream frame parser: sync hunt, header, payload store, result runs.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle while parsing. It hunts for the sync pair
// 0x81 0x88, captures a 16-byte big-endian header and then as many payload
// bytes as the header length announces; the first 32 payload bytes land in a
// 32x8 RAM, the rest are only counted. On the byte that completes a frame the
// input stalls and the stored bytes are read back through the RAM's single
// read port, one result word per cycle while the result side accepts (one
// result when there is no payload), each tagged with the header fields; tlast
// marks the final one. The input is held off (in_tready low) while the run is
// read, until the final result is loaded into the result register, and it
// stays held for longer when the result side stalls. A result register parts
// the two sides, so the next frame's bytes are taken while the last result waits.
// ----------------------------------------------------------------------------
module sync_length_frame_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] frame_width, [31:16] frame_height, [47:32] frame_rate,
  // [79:48] frame_number, [95:80] declared_payload_len,
  // [101:96] stored_payload_len, [106:102] payload_index,
  // [114:107] payload_byte, [119:115] zero
  output logic [slfp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,  // [0] has_payload_byte
  output logic                              out_tlast
);
  import slfp_pkg::*;

  logic                 emit_busy, frame_done;
  slfp_frame_t          frame_info;
  logic                 ram_we, ram_re;
  logic [PIDX_W-1:0]    ram_waddr, ram_raddr;
  logic [7:0]           ram_wdata, ram_rdata;

  // sync/header/payload front end
  slfp_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .emit_busy  (emit_busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .frame_done (frame_done),
    .frame_info (frame_info)
  );

  // payload store; writes only while parsing, reads only while emitting
  slfp_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result run sequencer and output register
  slfp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_done (frame_done),
    .frame_info (frame_info),
    .busy       (emit_busy),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/slfp_ram.sv =====
// ----------------------------------------------------------------------------
// slfp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module slfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/slfp_rx.sv =====
// ----------------------------------------------------------------------------
// slfp_rx
// Sync hunt, header capture and payload write into the store.
// ----------------------------------------------------------------------------
module slfp_rx (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,
  input  logic                         emit_busy,
  output logic                         ram_we,
  output logic [slfp_pkg::PIDX_W-1:0]  ram_waddr,
  output logic [7:0]                   ram_wdata,
  output logic                         frame_done,
  output slfp_pkg::slfp_frame_t        frame_info
);
  import slfp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      width_r, height_r, rate_r, decl_r;
  logic [31:0]      number_r;
  logic             acc, take, in_hdr, in_store;
  logic [POS_W-1:0] pos_inc, pidx, frame_end;
  logic [15:0]      decl_eff;
  logic [STORED_W-1:0] stored;

  assign in_tready = !emit_busy;
  assign acc       = in_tvalid && in_tready;

  // byte is kept unless it is noise while hunting or a bad second sync byte
  assign take = !((pos_r == POS_W'(0) && in_tdata != SYNC_FIRST) ||
                  (pos_r == POS_W'(1) && in_tdata != SYNC_SECOND));

  assign in_hdr    = pos_r < POS_W'(HDR_BYTES);
  assign pidx      = pos_r - POS_W'(HDR_BYTES);
  assign in_store  = !in_hdr && (pidx < POS_W'(PAYLOAD_CAPACITY));
  assign pos_inc   = pos_r + POS_W'(1);

  // length low byte may arrive on this very cycle
  assign decl_eff  = (pos_r == POS_W'(HDR_BYTES - 1)) ? {decl_r[15:8], in_tdata} : decl_r;
  assign frame_end = POS_W'(HDR_BYTES) + POS_W'(decl_eff);
  assign stored    = (decl_eff > 16'(PAYLOAD_CAPACITY)) ? STORED_W'(PAYLOAD_CAPACITY)
                                                        : decl_eff[STORED_W-1:0];

  assign frame_done = acc && take && (pos_inc >= POS_W'(HDR_BYTES)) && (pos_inc == frame_end);

  assign ram_we    = acc && take && in_store;
  assign ram_waddr = pidx[PIDX_W-1:0];
  assign ram_wdata = in_tdata;

  assign frame_info.width    = width_r;
  assign frame_info.height   = height_r;
  assign frame_info.rate     = rate_r;
  assign frame_info.number   = number_r;
  assign frame_info.declared = decl_eff;
  assign frame_info.stored   = stored;

  always_comb begin
    pos_nxt = pos_r;
    if (acc) begin
      if (frame_done) begin
        pos_nxt = '0;
      end else if (take) begin
        pos_nxt = pos_inc;
      end else begin
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // header fields: payload-type registers, no reset
  always_ff @(posedge clk) begin
    if (acc && take && in_hdr) begin
      case (pos_r[3:0])
        HDR_WIDTH_HI:  width_r[15:8]   <= in_tdata;
        HDR_WIDTH_LO:  width_r[7:0]    <= in_tdata;
        HDR_HEIGHT_HI: height_r[15:8]  <= in_tdata;
        HDR_HEIGHT_LO: height_r[7:0]   <= in_tdata;
        HDR_RATE_HI:   rate_r[15:8]    <= in_tdata;
        HDR_RATE_LO:   rate_r[7:0]     <= in_tdata;
        HDR_NUM_B3:    number_r[31:24] <= in_tdata;
        HDR_NUM_B2:    number_r[23:16] <= in_tdata;
        HDR_NUM_B1:    number_r[15:8]  <= in_tdata;
        HDR_NUM_B0:    number_r[7:0]   <= in_tdata;
        HDR_LEN_HI:    decl_r[15:8]    <= in_tdata;
        HDR_LEN_LO:    decl_r[7:0]     <= in_tdata;
        default: ;
      endcase
    end
  end

  // a frame never runs past header plus the largest length
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(HDR_BYTES + 65535))
    else $error("byte position past largest frame");

endmodule

// ===== rtl/slfp_emit.sv =====
// ----------------------------------------------------------------------------
// slfp_emit
// Reads the stored payload back and drives the result register.
// ----------------------------------------------------------------------------
module slfp_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              frame_done,
  input  slfp_pkg::slfp_frame_t             frame_info,
  output logic                              busy,
  output logic                              ram_re,
  output logic [slfp_pkg::PIDX_W-1:0]       ram_raddr,
  input  logic [7:0]                        ram_rdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [slfp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import slfp_pkg::*;

  slfp_frame_t         info_r;
  logic                busy_r, pend_r, oval_r;
  logic [STORED_W-1:0] n_r, rk_r;
  logic [PIDX_W-1:0]   pk_r;
  logic                has, load, last_now;
  logic [OUT_TDATA_W-1:0] tdata_r;
  logic                tuser_r, tlast_r;

  assign busy     = busy_r;
  assign has      = info_r.stored != '0;
  assign load     = pend_r && (!oval_r || out_tready);
  assign last_now = (STORED_W'(pk_r) + STORED_W'(1)) == n_r;
  assign ram_re   = busy_r && (rk_r != n_r) && (!pend_r || load);
  assign ram_raddr = rk_r[PIDX_W-1:0];

  assign out_tvalid = oval_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;
  assign out_tlast  = tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
      rk_r   <= '0;
    end else begin
      if (frame_done) begin
        busy_r <= 1'b1;
        pend_r <= 1'b0;
        rk_r   <= '0;
      end else begin
        if (ram_re) begin
          rk_r   <= rk_r + STORED_W'(1);
          pend_r <= 1'b1;
        end else if (load) begin
          pend_r <= 1'b0;
        end
        if (load && last_now) begin
          busy_r <= 1'b0;
        end
      end
      if (load) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
    end
  end

  // frame copy, read index and result payload
  always_ff @(posedge clk) begin
    if (frame_done) begin
      info_r <= frame_info;
      n_r    <= (frame_info.stored == '0) ? STORED_W'(1) : frame_info.stored;
    end
    if (ram_re) begin
      pk_r <= rk_r[PIDX_W-1:0];
    end
    if (load) begin
      tdata_r <= {5'd0,
                  has ? ram_rdata : 8'd0,
                  has ? INDEX_W'(pk_r) : INDEX_W'(0),
                  info_r.stored,
                  info_r.declared,
                  info_r.number,
                  info_r.rate,
                  info_r.height,
                  info_r.width};
      tuser_r <= has;
      tlast_r <= last_now;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> !busy_r)
    else $error("frame completed while a run is still being read");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rk_r <= n_r)
    else $error("read issue count past run length");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_now && !frame_done) |=> (!busy_r && out_tvalid && out_tlast))
    else $error("final result did not end the run");

endmodule
